/* sv/cpp_pkg.sv */
`timescale 1ns / 1ps
package cpp_pkg;

    localparam logic [1:0]  STAT_DIVERGE = 2'd0;
    localparam logic [1:0]  STAT_PREDICT = 2'd1;
    localparam logic [1:0]  STAT_ZERO    = 2'd2;

    localparam logic [23:0] MAX24        = 24'hFFFFFF;
    localparam logic [19:0] MARGIN_RESET = 20'd4608;

    localparam int DIV_STAGES  = 24;
    localparam int SQRT_STAGES = 25;
    localparam int SQRT_W      = 50;

    typedef struct packed {
        logic signed [24:0] ddx;
        logic signed [24:0] ddy;
        logic signed [16:0] dvx;
        logic signed [16:0] dvy;
    } geo_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       sat;
        geo_t       geo;
    } side_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] hit_time;
        logic        big;
    } tag_t;

    function automatic logic [23:0] abs25(input logic signed [24:0] v);
        logic [24:0] r;
        r = v[24] ? 25'(-v) : 25'(v);
        return r[23:0];
    endfunction

    function automatic logic [15:0] abs17(input logic signed [16:0] v);
        logic [16:0] r;
        r = v[16] ? 17'(-v) : 17'(v);
        return r[15:0];
    endfunction

endpackage

/* sv/pairwise_collision_predictor.sv */
`timescale 1ns / 1ps
// Channel | Dir | Handshake         | Word
// s_      | in  | s_tvalid/s_tready | s_tdata: own_x, own_y, own_vx, own_vy,
//         |     |                   |          other_x, other_y, other_vx, other_vy
// m_      | out | m_tvalid/m_tready | m_tdata: status, hit_time, hit_distance
// cfg_    | in  | cfg_valid/ready   | cfg_data: margin
//
// One word a cycle in and out while the output is not stalled. Stages: 2 front
// stages, 24 stages of the divider (one quotient bit each), 4 distance stages,
// 25 stages of the square root (one root bit each) and the output register.
// aresetn clears all valid bits and loads the margin reset value.
// Each stage holds while the one after it is full and stalled, so empty stages
// keep taking words while a result waits.
module pairwise_collision_predictor (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // own_x[23:0] own_y[47:24] own_vx[63:48] own_vy[79:64]
    // other_x[103:80] other_y[127:104] other_vx[143:128] other_vy[159:144]
    input  logic [159:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0] hit_time[25:2] hit_distance[49:26], zeros above
    output logic [55:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [19:0]  cfg_data
);
    import cpp_pkg::*;

    logic [19:0] margin_reg;
    logic        f_valid, f_ready, d_valid, d_ready, e_valid, e_ready, q_valid, q_ready;
    side_t       f_side, d_side;
    logic [23:0] f_gap, d_q;
    logic [15:0] f_cl;
    tag_t        e_tag, q_tag;
    logic [48:0] e_sum;
    logic [24:0] q_root;
    logic        m_valid_reg;
    logic [1:0]  st_reg, st_next;
    logic [23:0] tm_reg, dist_reg, dist_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg <= MARGIN_RESET;
        end else if (cfg_valid) begin
            margin_reg <= cfg_data;
        end
    end

    cpp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .own_x    ($signed(s_tdata[23:0])),
        .own_y    ($signed(s_tdata[47:24])),
        .own_vx   ($signed(s_tdata[63:48])),
        .own_vy   ($signed(s_tdata[79:64])),
        .other_x  ($signed(s_tdata[103:80])),
        .other_y  ($signed(s_tdata[127:104])),
        .other_vx ($signed(s_tdata[143:128])),
        .other_vy ($signed(s_tdata[159:144])),
        .margin   (margin_reg),
        .out_valid(f_valid),
        .out_ready(f_ready),
        .out_side (f_side),
        .out_gap  (f_gap),
        .out_cl   (f_cl)
    );

    cpp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (f_valid),
        .in_ready (f_ready),
        .in_side  (f_side),
        .in_gap   (f_gap),
        .in_cl    (f_cl),
        .out_valid(d_valid),
        .out_ready(d_ready),
        .out_side (d_side),
        .out_q    (d_q)
    );

    cpp_dist u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (d_valid),
        .in_ready (d_ready),
        .in_side  (d_side),
        .in_q     (d_q),
        .out_valid(e_valid),
        .out_ready(e_ready),
        .out_tag  (e_tag),
        .out_sum  (e_sum)
    );

    cpp_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (e_valid),
        .in_ready (e_ready),
        .in_tag   (e_tag),
        .in_sum   (e_sum),
        .out_valid(q_valid),
        .out_ready(q_ready),
        .out_tag  (q_tag),
        .out_root (q_root)
    );

    assign q_ready = !m_valid_reg || m_tready;

    always_comb begin
        st_next = q_tag.kind;
        if (q_tag.kind != STAT_PREDICT || q_tag.big || q_root[24]) begin
            dist_next = MAX24;
        end else begin
            dist_next = q_root[23:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (q_ready) begin
            m_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_ready) begin
            st_reg   <= st_next;
            tm_reg   <= q_tag.hit_time;
            dist_reg <= dist_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, dist_reg, tm_reg, st_reg};

`ifndef NO_ASSERTIONS
    a_diverge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st_reg == STAT_DIVERGE |-> tm_reg == '0 && dist_reg == MAX24)
        else $error("diverging word carries a time or distance");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st_reg == STAT_ZERO |-> tm_reg == MAX24 && dist_reg == MAX24)
        else $error("zero closing speed word not saturated");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && !q_ready |=> q_valid && $stable(q_tag))
        else $error("square root output changed while stalled");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !q_valid |=> !m_tvalid)
        else $error("output word repeated");
`endif

endmodule

/* sv/cpp_front.sv */
`timescale 1ns / 1ps
module cpp_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [23:0]   own_x,
    input  logic signed [23:0]   own_y,
    input  logic signed [15:0]   own_vx,
    input  logic signed [15:0]   own_vy,
    input  logic signed [23:0]   other_x,
    input  logic signed [23:0]   other_y,
    input  logic signed [15:0]   other_vx,
    input  logic signed [15:0]   other_vy,
    input  logic [19:0]          margin,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cpp_pkg::side_t       out_side,
    output logic [23:0]          out_gap,
    output logic [15:0]          out_cl
);
    import cpp_pkg::*;

    logic [1:0]  v_reg;
    logic        en0, en1;
    geo_t        geo_reg, geo_next;
    logic        div_reg, div_next;
    side_t       side_reg, side_next;
    logic [23:0] gap_reg, gap_next;
    logic [15:0] cl_reg, cl_next;
    logic signed [20:0] m_s;
    logic [23:0] ax, ay;

    assign en1      = !v_reg[1] || out_ready;
    assign en0      = !v_reg[0] || en1;
    assign in_ready = en0;

    always_comb begin
        m_s          = $signed({1'b0, margin});
        geo_next.ddx = $signed({other_x[23], other_x}) - $signed({own_x[23], own_x});
        geo_next.ddy = $signed({other_y[23], other_y}) - $signed({own_y[23], own_y});
        geo_next.dvx = $signed({other_vx[15], other_vx}) - $signed({own_vx[15], own_vx});
        geo_next.dvy = $signed({other_vy[15], other_vy}) - $signed({own_vy[15], own_vy});
        div_next = (geo_next.ddx > m_s && geo_next.dvx >= 0)
                || (geo_next.ddx < -m_s && geo_next.dvx <= 0)
                || (geo_next.ddy > m_s && geo_next.dvy >= 0)
                || (geo_next.ddy < -m_s && geo_next.dvy <= 0);
    end

    // Pick the axis with the larger gap; ties go to y.
    always_comb begin
        ax = abs25(geo_reg.ddx);
        ay = abs25(geo_reg.ddy);
        if (ax > ay) begin
            gap_next = ax;
            cl_next  = abs17(geo_reg.dvx);
        end else begin
            gap_next = ay;
            cl_next  = abs17(geo_reg.dvy);
        end
        side_next.geo = geo_reg;
        side_next.sat = {8'd0, gap_next} >= {cl_next, 16'd0};
        if (div_reg) begin
            side_next.kind = STAT_DIVERGE;
        end else if (cl_next == 16'd0) begin
            side_next.kind = STAT_ZERO;
        end else begin
            side_next.kind = STAT_PREDICT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en0) v_reg[0] <= in_valid;
            if (en1) v_reg[1] <= v_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en0) begin
            geo_reg <= geo_next;
            div_reg <= div_next;
        end
        if (en1) begin
            side_reg <= side_next;
            gap_reg  <= gap_next;
            cl_reg   <= cl_next;
        end
    end

    assign out_valid = v_reg[1];
    assign out_side  = side_reg;
    assign out_gap   = gap_reg;
    assign out_cl    = cl_reg;

endmodule

/* sv/cpp_div.sv */
`timescale 1ns / 1ps
module cpp_div (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  cpp_pkg::side_t   in_side,
    input  logic [23:0]      in_gap,
    input  logic [15:0]      in_cl,
    output logic             out_valid,
    input  logic             out_ready,
    output cpp_pkg::side_t   out_side,
    output logic [23:0]      out_q
);
    import cpp_pkg::*;

    logic [DIV_STAGES-1:0] v_reg;
    logic [DIV_STAGES:0]   en;
    logic [15:0] rem_reg  [DIV_STAGES];
    logic [23:0] q_reg    [DIV_STAGES];
    logic [15:0] glow_reg [DIV_STAGES];
    logic [15:0] cl_reg   [DIV_STAGES];
    side_t       side_reg [DIV_STAGES];

    assign en[DIV_STAGES] = out_ready;
    assign in_ready       = en[0];

    // One quotient bit a stage, most significant first; remainder stays below the divisor for unsaturated words.
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_st
        localparam int I = DIV_STAGES - 1 - k;
        logic        vp;
        logic [15:0] remp, glowp, clp;
        logic [23:0] qp;
        side_t       sidep;
        logic        dbit;
        logic [16:0] t;
        logic        ge;
        logic [16:0] diff;

        if (k == 0) begin : g_src
            assign vp    = in_valid;
            assign remp  = {8'd0, in_gap[23:16]};
            assign qp    = '0;
            assign glowp = in_gap[15:0];
            assign clp   = in_cl;
            assign sidep = in_side;
        end else begin : g_src
            assign vp    = v_reg[k-1];
            assign remp  = rem_reg[k-1];
            assign qp    = q_reg[k-1];
            assign glowp = glow_reg[k-1];
            assign clp   = cl_reg[k-1];
            assign sidep = side_reg[k-1];
        end

        if (I >= 8) begin : g_bit
            assign dbit = glowp[I-8];
        end else begin : g_bit
            assign dbit = 1'b0;
        end

        assign en[k] = !v_reg[k] || en[k+1];
        assign t     = {remp, dbit};
        assign ge    = t >= {1'b0, clp};
        assign diff  = t - {1'b0, clp};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en[k]) begin
                v_reg[k] <= vp;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                rem_reg[k]  <= ge ? diff[15:0] : t[15:0];
                q_reg[k]    <= {qp[22:0], ge};
                glow_reg[k] <= glowp;
                cl_reg[k]   <= clp;
                side_reg[k] <= sidep;
            end
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];
    assign out_q     = q_reg[DIV_STAGES-1];

endmodule

/* sv/cpp_dist.sv */
`timescale 1ns / 1ps
module cpp_dist (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  cpp_pkg::side_t   in_side,
    input  logic [23:0]      in_q,
    output logic             out_valid,
    input  logic             out_ready,
    output cpp_pkg::tag_t    out_tag,
    output logic [48:0]      out_sum
);
    import cpp_pkg::*;

    logic [3:0] v_reg;
    logic [3:0] en;

    tag_t  tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    tag_t  tag1_next, tag2_next;
    logic signed [24:0] ddx1_reg, ddy1_reg;
    logic signed [41:0] px_reg, py_reg, px_next, py_next;
    logic [23:0] mx_reg, my_reg;
    logic [47:0] sx_reg, sy_reg;
    logic [48:0] sum_reg;
    logic signed [42:0] rx, ry;
    logic [42:0] axr, ayr, rndx, rndy;

    assign en[3]    = !v_reg[3] || out_ready;
    assign en[2]    = !v_reg[2] || en[3];
    assign en[1]    = !v_reg[1] || en[2];
    assign en[0]    = !v_reg[0] || en[1];
    assign in_ready = en[0];

    // Settle the reported time first; the saturated time is the one advanced by.
    always_comb begin
        tag1_next.kind = in_side.kind;
        tag1_next.big  = 1'b0;
        if (in_side.kind == STAT_DIVERGE) begin
            tag1_next.hit_time = '0;
        end else if (in_side.kind == STAT_ZERO || in_side.sat) begin
            tag1_next.hit_time = MAX24;
        end else begin
            tag1_next.hit_time = in_q;
        end
        px_next = $signed({1'b0, tag1_next.hit_time}) * in_side.geo.dvx;
        py_next = $signed({1'b0, tag1_next.hit_time}) * in_side.geo.dvy;
    end

    // Offset in Q.8, magnitude rounded half up to whole units.
    always_comb begin
        rx   = $signed({{10{ddx1_reg[24]}}, ddx1_reg, 8'd0}) + $signed({px_reg[41], px_reg});
        ry   = $signed({{10{ddy1_reg[24]}}, ddy1_reg, 8'd0}) + $signed({py_reg[41], py_reg});
        axr  = rx[42] ? 43'(-rx) : 43'(rx);
        ayr  = ry[42] ? 43'(-ry) : 43'(ry);
        rndx = axr + 43'd128;
        rndy = ayr + 43'd128;
        tag2_next     = tag1_reg;
        tag2_next.big = (|rndx[42:32]) || (|rndy[42:32]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= in_valid;
            if (en[1]) v_reg[1] <= v_reg[0];
            if (en[2]) v_reg[2] <= v_reg[1];
            if (en[3]) v_reg[3] <= v_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            tag1_reg <= tag1_next;
            ddx1_reg <= in_side.geo.ddx;
            ddy1_reg <= in_side.geo.ddy;
            px_reg   <= px_next;
            py_reg   <= py_next;
        end
        if (en[1]) begin
            tag2_reg <= tag2_next;
            mx_reg   <= rndx[31:8];
            my_reg   <= rndy[31:8];
        end
        if (en[2]) begin
            tag3_reg <= tag2_reg;
            sx_reg   <= mx_reg * mx_reg;
            sy_reg   <= my_reg * my_reg;
        end
        if (en[3]) begin
            tag4_reg <= tag3_reg;
            sum_reg  <= {1'b0, sx_reg} + {1'b0, sy_reg};
        end
    end

    assign out_valid = v_reg[3];
    assign out_tag   = tag4_reg;
    assign out_sum   = sum_reg;

endmodule

/* sv/cpp_sqrt.sv */
`timescale 1ns / 1ps
module cpp_sqrt (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  cpp_pkg::tag_t    in_tag,
    input  logic [48:0]      in_sum,
    output logic             out_valid,
    input  logic             out_ready,
    output cpp_pkg::tag_t    out_tag,
    output logic [24:0]      out_root
);
    import cpp_pkg::*;

    logic [SQRT_STAGES-1:0] v_reg;
    logic [SQRT_STAGES:0]   en;
    logic [SQRT_W-1:0] n_reg   [SQRT_STAGES];
    logic [SQRT_W-1:0] res_reg [SQRT_STAGES];
    tag_t              tag_reg [SQRT_STAGES];

    assign en[SQRT_STAGES] = out_ready;
    assign in_ready        = en[0];

    // One root bit a stage, trial bit moving down by two places each time.
    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_st
        localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (2 * (SQRT_STAGES - 1 - k));
        logic              vp;
        logic [SQRT_W-1:0] np, rp, trial;
        tag_t              tp;

        if (k == 0) begin : g_src
            assign vp = in_valid;
            assign np = {1'b0, in_sum};
            assign rp = '0;
            assign tp = in_tag;
        end else begin : g_src
            assign vp = v_reg[k-1];
            assign np = n_reg[k-1];
            assign rp = res_reg[k-1];
            assign tp = tag_reg[k-1];
        end

        assign en[k] = !v_reg[k] || en[k+1];
        assign trial = rp + BIT;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en[k]) begin
                v_reg[k] <= vp;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                if (np >= trial) begin
                    n_reg[k]   <= np - trial;
                    res_reg[k] <= (rp >> 1) + BIT;
                end else begin
                    n_reg[k]   <= np;
                    res_reg[k] <= rp >> 1;
                end
                tag_reg[k] <= tp;
            end
        end
    end

    assign out_valid = v_reg[SQRT_STAGES-1];
    assign out_tag   = tag_reg[SQRT_STAGES-1];
    assign out_root  = res_reg[SQRT_STAGES-1][24:0];

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
    import cpp_pkg::*;

    typedef struct packed {
        logic signed [23:0] own_x;
        logic signed [23:0] own_y;
        logic signed [15:0] own_vx;
        logic signed [15:0] own_vy;
        logic signed [23:0] oth_x;
        logic signed [23:0] oth_y;
        logic signed [15:0] oth_vx;
        logic signed [15:0] oth_vy;
    } pair_t;

    // highest field first, so status lands in the lowest bits
    typedef struct packed {
        logic [23:0] hit_distance;
        logic [23:0] hit_time;
        logic [1:0]  status;
    } hit_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [55:0]  m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [19:0]  cfg_data = '0;

    logic [19:0] margin_q = MARGIN_RESET;
    hit_t        hits_due[$];
    int          n_fail = 0;
    int          send_gap_pct = 0;
    int          stall_pct = 0;
    int          hold_off = 0;
    longint      cycle = 0;

    pairwise_collision_predictor i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > 400000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic longint unsigned mag64(input longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic hit_t predict_hit(input pair_t p);
        hit_t h;
        longint m, ox, oy, tx, ty, ovx, ovy, tvx, tvy, ddx, ddy, dvx, dvy, rx, ry;
        longint unsigned gap, cl, q, mx, my;
        m = margin_q;
        ox = p.own_x; oy = p.own_y; ovx = p.own_vx; ovy = p.own_vy;
        tx = p.oth_x; ty = p.oth_y; tvx = p.oth_vx; tvy = p.oth_vy;
        if ((ox + m < tx && ovx <= tvx) || (ox - m > tx && ovx >= tvx) ||
            (oy + m < ty && ovy <= tvy) || (oy - m > ty && ovy >= tvy)) begin
            h.status = STAT_DIVERGE; h.hit_time = '0; h.hit_distance = MAX24;
            return h;
        end
        ddx = tx - ox; ddy = ty - oy; dvx = tvx - ovx; dvy = tvy - ovy;
        if (mag64(ddx) > mag64(ddy)) begin
            gap = mag64(ddx); cl = mag64(dvx);
        end else begin
            gap = mag64(ddy); cl = mag64(dvy);
        end
        if (cl == 0) begin
            h.status = STAT_ZERO; h.hit_time = MAX24; h.hit_distance = MAX24;
            return h;
        end
        q = (gap << 8) / cl;
        if (q > MAX24) q = MAX24;
        rx = ddx * 256 + longint'(q) * dvx;
        ry = ddy * 256 + longint'(q) * dvy;
        mx = (mag64(rx) + 128) >> 8;
        my = (mag64(ry) + 128) >> 8;
        h.status = STAT_PREDICT;
        h.hit_time = q[23:0];
        if (mx > MAX24 || my > MAX24) h.hit_distance = MAX24;
        else begin
            q = root_floor(mx * mx + my * my);
            h.hit_distance = q > MAX24 ? MAX24 : q[23:0];
        end
        return h;
    endfunction

    // receiver: random stalls, or a long counted hold-off
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        hit_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[49:0];
            if (hits_due.size() == 0) begin
                $error("result word with nothing expected");
                n_fail++;
            end else begin
                want = hits_due.pop_front();
                if (got.status != want.status) begin
                    $error("status exp %0d got %0d", want.status, got.status);
                    n_fail++;
                end
                if (got.hit_time != want.hit_time) begin
                    $error("hit_time exp %h got %h", want.hit_time, got.hit_time);
                    n_fail++;
                end
                if (got.hit_distance != want.hit_distance) begin
                    $error("hit_distance exp %h got %h", want.hit_distance,
                           got.hit_distance);
                    n_fail++;
                end
            end
        end
    end

    // valid stays high into the next word; drop it only for an idle cycle
    task automatic send_pair(input pair_t p);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p.oth_vy, p.oth_vx, p.oth_y, p.oth_x,
                     p.own_vy, p.own_vx, p.own_y, p.own_x};
        do @(posedge aclk); while (!s_tready);
        hits_due.push_back(predict_hit(p));
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (hits_due.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
    endtask

    task automatic write_margin(input logic [19:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        margin_q = v;
    endtask

    function automatic pair_t rand_pair(input bit near);
        pair_t p;
        p = {$urandom, $urandom, $urandom, $urandom, $urandom};
        if (near) begin
            // keep the pair close so most words get past the axis tests
            p.oth_x = p.own_x + 24'($signed($urandom_range(8191)) - 4096);
            p.oth_y = p.own_y + 24'($signed($urandom_range(8191)) - 4096);
            if ($urandom_range(3) == 0) p.oth_vx = p.own_vx;
            if ($urandom_range(3) == 0) p.oth_vy = p.own_vy;
        end
        return p;
    endfunction

    task automatic test_directed;
        pair_t p;
        p = '0;
        send_pair(p);                                 // same place, zero closing
        p.oth_x = 24'sd10000; send_pair(p);           // beyond reset margin, not closing
        p.own_vx = 16'sd256; send_pair(p);            // beyond reset margin, approaching
        p = '0; p.own_x = 24'sd10000; p.oth_vx = 16'sd256; send_pair(p);
        p = '0; p.oth_y = 24'sd10000; p.own_vy = -16'sd256; send_pair(p);
        p = '0; p.own_y = 24'sd10000; p.own_vy = 16'sd256; send_pair(p);
        p = '0; p.oth_x = 24'sd100; p.oth_y = 24'sd100; p.own_vy = 16'sd3;
        send_pair(p);                                 // equal gaps pick y
        p = '0; p.own_x = 24'h800000; p.oth_x = 24'h7FFFFF;
        p.own_vx = 16'h7FFF; p.oth_vx = 16'h8000; send_pair(p);
        p = '0; p.oth_x = 24'h7FFFFF; p.own_vx = 16'sd1; p.oth_vy = 16'h8000;
        send_pair(p);                                 // saturated time
        p = '1; send_pair(p);
        p = {24'h800000, 24'h800000, 16'h8000, 16'h8000,
             24'h7FFFFF, 24'h7FFFFF, 16'h7FFF, 16'h7FFF};
        send_pair(p);
        p.own_vx = 16'h7FFF; p.own_vy = 16'h7FFF; send_pair(p);
    endtask

    task automatic test_random(input int n);
        repeat (n) send_pair(rand_pair($urandom_range(9) < 8));
    endtask

    task automatic test_backpressure;
        hold_off = 300;
        stall_pct = 0;
        send_gap_pct = 0;
        test_random(120);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(80);
        write_margin(20'd0);
        test_directed();
        test_random(60);
        write_margin(20'hFFFFF);
        test_directed();
        send_gap_pct = 48;
        test_random(60);
        write_margin(20'($urandom));
        send_gap_pct = 0; stall_pct = 48;
        test_random(60);
        write_margin(MARGIN_RESET);
        send_gap_pct = 10; stall_pct = 10;
        test_random(60);
        test_backpressure();
        drain();
        if (n_fail == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
